// ===== rtl/sct_pkg.sv =====
// Shared types and constants of the source code tokenizer.
// Holds the transaction structs and token kind codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       has_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic              item_kind;
      logic [5:0]        token_kind;
      logic [7:0]        text_char;
      logic [15:0]       line;
      logic [15:0]       column;
      logic signed [63:0] number_value;
      logic [4:0]        fraction_digits;
      logic              last_of_run;
   } rsp_type;

   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 8;

   localparam logic ITEM_TOKEN = 1'b0;
   localparam logic ITEM_TEXT  = 1'b1;

   localparam logic [5:0] K_END        = 6'd0;
   localparam logic [5:0] K_INT        = 6'd1;
   localparam logic [5:0] K_DEC        = 6'd2;
   localparam logic [5:0] K_STR        = 6'd3;
   localparam logic [5:0] K_IDENT      = 6'd4;
   localparam logic [5:0] K_KW0        = 6'd5;
   localparam logic [5:0] K_PLUS       = 6'd17;
   localparam logic [5:0] K_PLUSPLUS   = 6'd18;
   localparam logic [5:0] K_MINUS      = 6'd19;
   localparam logic [5:0] K_MINUSMINUS = 6'd20;
   localparam logic [5:0] K_STAR       = 6'd21;
   localparam logic [5:0] K_SLASH      = 6'd22;
   localparam logic [5:0] K_PERCENT    = 6'd23;
   localparam logic [5:0] K_ASSIGN     = 6'd24;
   localparam logic [5:0] K_EQ         = 6'd25;
   localparam logic [5:0] K_NOT        = 6'd26;
   localparam logic [5:0] K_NEQ        = 6'd27;
   localparam logic [5:0] K_LT         = 6'd28;
   localparam logic [5:0] K_LTE        = 6'd29;
   localparam logic [5:0] K_GT         = 6'd30;
   localparam logic [5:0] K_GTE        = 6'd31;
   localparam logic [5:0] K_AND        = 6'd32;
   localparam logic [5:0] K_OR         = 6'd33;
   localparam logic [5:0] K_SEMI       = 6'd34;
   localparam logic [5:0] K_COMMA      = 6'd35;
   localparam logic [5:0] K_LPAREN     = 6'd36;
   localparam logic [5:0] K_RPAREN     = 6'd37;
   localparam logic [5:0] K_LBRACE     = 6'd38;
   localparam logic [5:0] K_RBRACE     = 6'd39;
   localparam logic [5:0] K_LBRACKET   = 6'd40;
   localparam logic [5:0] K_RBRACKET   = 6'd41;
   localparam logic [5:0] K_COLON      = 6'd42;
   localparam logic [5:0] K_UNKNOWN    = 6'd43;

endpackage

`default_nettype wire

// ===== rtl/sct_lexer.sv =====
// Scanner state and single-pass lexing step: one registered item in,
// up to four results out. Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_lexer
   import sct_pkg::*;
#(
   parameter int STRING_LIMIT = 256,
   parameter int NAME_LIMIT   = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_go,
   input  wire req_type item,
   output rsp_type      results [MAX_RESULTS],
   output logic [2:0]   result_count
);

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_COMMENT, M_MINUS, M_OP1,
      M_INT, M_FRAC, M_STRING, M_ESCAPE, M_IDENT
   } mode_type;

   localparam logic [63:0] MANT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   function automatic logic [3:0] kw_len(input int k);
      case (k)
         0, 1, 2, 5: kw_len = 4'd2;
         3, 6:       kw_len = 4'd3;
         7, 11:      kw_len = 4'd4;
         9:          kw_len = 4'd8;
         default:    kw_len = 4'd5;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
      logic [63:0] s;
      case (k)
         0:       s = {"fn", 48'd0};
         1:       s = {"rn", 48'd0};
         2:       s = {"if", 48'd0};
         3:       s = {"for", 40'd0};
         4:       s = {"while", 24'd0};
         5:       s = {"in", 48'd0};
         6:       s = {"out", 40'd0};
         7:       s = {"time", 32'd0};
         8:       s = {"break", 24'd0};
         9:       s = "continue";
         10:      s = {"array", 24'd0};
         default: s = {"http", 32'd0};
      endcase
      kw_char = s[63 - 8 * i -: 8];
   endfunction

   function automatic logic [11:0] kw_update(input logic [11:0] km, input logic [8:0] tl,
                                              input logic [7:0] c);
      logic [11:0] r;
      r = km;
      for (int k = 0; k < 12; k++) begin
         if (tl >= 9'(kw_len(k)) || kw_char(k, tl[2:0]) != c) r[k] = 1'b0;
      end
      kw_update = r;
   endfunction

   function automatic logic [5:0] single_op(input logic [7:0] c);
      case (c)
         "+":     single_op = K_PLUS;
         "=":     single_op = K_ASSIGN;
         "!":     single_op = K_NOT;
         "<":     single_op = K_LT;
         ">":     single_op = K_GT;
         default: single_op = K_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] pair_op(input logic [7:0] f, input logic [7:0] c);
      pair_op = K_END;
      if (f == "+" && c == "+") pair_op = K_PLUSPLUS;
      if (f == "=" && c == "=") pair_op = K_EQ;
      if (f == "!" && c == "=") pair_op = K_NEQ;
      if (f == "<" && c == "=") pair_op = K_LTE;
      if (f == ">" && c == "=") pair_op = K_GTE;
      if (f == "&" && c == "&") pair_op = K_AND;
      if (f == "|" && c == "|") pair_op = K_OR;
   endfunction

   function automatic logic [63:0] add_digit(input logic [63:0] m, input logic [7:0] c);
      logic [66:0] t;
      t = {m, 3'b000} + {2'b00, m, 1'b0} + 67'(c[3:0]);
      add_digit = (t > 67'(MANT_MAX)) ? MANT_MAX : t[63:0];
   endfunction

   function automatic rsp_type mk(input logic ik, input logic [5:0] kind, input logic [7:0] ch,
                                  input logic [15:0] ln, input logic [15:0] col,
                                  input logic [63:0] val, input logic [4:0] frac);
      rsp_type r;
      r.item_kind       = ik;
      r.token_kind      = kind;
      r.text_char       = ch;
      r.line            = ln;
      r.column          = col;
      r.number_value    = val;
      r.fraction_digits = frac;
      r.last_of_run     = 1'b0;
      mk = r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   mode_type    mode_ff, mode_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] cur_line_ff, cur_line_in, cur_col_ff, cur_col_in;
   logic [15:0] start_line_ff, start_line_in, start_col_ff, start_col_in;
   logic [63:0] mant_ff, mant_in;
   logic [4:0]  frac_ff, frac_in;
   logic        neg_ff, neg_in;
   logic [8:0]  tlen_ff, tlen_in;
   logic [11:0] kw_ff, kw_in;

   always_comb begin
      logic [7:0]  c;
      logic        do_idle;
      logic [2:0]  n;
      logic [31:0] low;
      logic [5:0]  kind;
      rsp_type     r [MAX_RESULTS];
      c = item.source_byte;
      do_idle = 1'b0;
      n = 3'd0;
      low = 32'd0;
      kind = K_IDENT;
      for (int i = 0; i < MAX_RESULTS; i++) r[i] = mk(ITEM_TOKEN, K_END, 8'd0, 16'd0, 16'd0, 64'd0, 5'd0);
      mode_in = mode_ff; held_in = held_ff;
      cur_line_in = cur_line_ff; cur_col_in = cur_col_ff;
      start_line_in = start_line_ff; start_col_in = start_col_ff;
      mant_in = mant_ff; frac_in = frac_ff; neg_in = neg_ff;
      tlen_in = tlen_ff; kw_in = kw_ff;

      if (item.has_byte) begin
         unique case (mode_in)
            M_SLASH: begin
               if (c == "/") mode_in = M_COMMENT;
               else begin
                  r[n[1:0]] = mk(ITEM_TOKEN, K_SLASH, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; do_idle = 1'b1;
               end
            end
            M_COMMENT: if (c == 8'h0A) mode_in = M_IDLE;
            M_MINUS: begin
               if (c == "-") begin
                  r[n[1:0]] = mk(ITEM_TOKEN, K_MINUSMINUS, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; mode_in = M_IDLE;
               end else if (is_digit(c)) begin
                  mode_in = M_INT; mant_in = 64'(c[3:0]); neg_in = 1'b1; frac_in = 5'd0;
               end else begin
                  r[n[1:0]] = mk(ITEM_TOKEN, K_MINUS, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; do_idle = 1'b1;
               end
            end
            M_OP1: begin
               kind = pair_op(held_in, c);
               if (kind != K_END) begin
                  r[n[1:0]] = mk(ITEM_TOKEN, kind, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; mode_in = M_IDLE;
               end else begin
                  r[n[1:0]] = mk(ITEM_TOKEN, single_op(held_in), 8'd0, start_line_in, start_col_in,
                                 64'd0, 5'd0);
                  n = n + 3'd1; do_idle = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(c)) mant_in = add_digit(mant_in, c);
               else if (c == ".") begin
                  mode_in = M_FRAC; frac_in = 5'd0;
               end else begin
                  low = neg_in ? 32'd0 - mant_in[31:0] : mant_in[31:0];
                  r[n[1:0]] = mk(ITEM_TOKEN, K_INT, 8'd0, start_line_in, start_col_in,
                                 {{32{low[31]}}, low}, 5'd0);
                  n = n + 3'd1; do_idle = 1'b1;
               end
            end
            M_FRAC: begin
               if (is_digit(c)) begin
                  if (frac_in < 5'd18) begin
                     mant_in = add_digit(mant_in, c); frac_in = frac_in + 5'd1;
                  end
               end else begin
                  r[n[1:0]] = mk(ITEM_TOKEN, K_DEC, 8'd0, start_line_in, start_col_in,
                                 neg_in ? 64'd0 - mant_in : mant_in, frac_in);
                  n = n + 3'd1; do_idle = 1'b1;
               end
            end
            M_STRING: begin
               if (tlen_in >= 9'(STRING_LIMIT - 1)) begin
                  r[n[1:0]] = mk(ITEM_TOKEN, K_STR, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1;
                  if (c == "\"") mode_in = M_IDLE;
                  else do_idle = 1'b1;
               end else if (c == "\"") begin
                  r[n[1:0]] = mk(ITEM_TOKEN, K_STR, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; mode_in = M_IDLE;
               end else if (c == "\\") mode_in = M_ESCAPE;
               else begin
                  r[n[1:0]] = mk(ITEM_TEXT, K_STR, c, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; tlen_in = tlen_in + 9'd1;
               end
            end
            M_ESCAPE: begin
               r[n[1:0]] = mk(ITEM_TEXT, K_STR, (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : c,
                              start_line_in, start_col_in, 64'd0, 5'd0);
               n = n + 3'd1; tlen_in = tlen_in + 9'd1; mode_in = M_STRING;
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == "_") begin
                  kw_in = kw_update(kw_in, tlen_in, c);
                  if (tlen_in < 9'(NAME_LIMIT - 1)) begin
                     r[n[1:0]] = mk(ITEM_TEXT, K_IDENT, c, start_line_in, start_col_in, 64'd0, 5'd0);
                     n = n + 3'd1;
                  end
                  if (tlen_in != 9'd511) tlen_in = tlen_in + 9'd1;
               end else begin
                  kind = K_IDENT;
                  for (int k = 0; k < 12; k++)
                     if (kw_in[k] && tlen_in == 9'(kw_len(k))) kind = K_KW0 + 6'(k);
                  r[n[1:0]] = mk(ITEM_TOKEN, kind, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1; do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         if (do_idle) begin
            start_line_in = cur_line_in;
            start_col_in  = cur_col_in;
            mode_in = M_IDLE;
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
               mode_in = M_IDLE;
            end else if (is_digit(c)) begin
               mode_in = M_INT; mant_in = 64'(c[3:0]); neg_in = 1'b0; frac_in = 5'd0;
            end else if (is_alpha(c) || c == "_" || c == "$") begin
               mode_in = M_IDENT;
               kw_in = kw_update(12'hFFF, 9'd0, c);
               r[n[1:0]] = mk(ITEM_TEXT, K_IDENT, c, start_line_in, start_col_in, 64'd0, 5'd0);
               n = n + 3'd1;
               tlen_in = 9'd1;
            end else begin
               kind = K_END;
               case (c) inside
                  "/": mode_in = M_SLASH;
                  "-": mode_in = M_MINUS;
                  "\"": begin
                     mode_in = M_STRING; tlen_in = 9'd0;
                  end
                  "+", "=", "!", "<", ">", "&", "|": begin
                     mode_in = M_OP1; held_in = c;
                  end
                  "*": kind = K_STAR;
                  "%": kind = K_PERCENT;
                  ";": kind = K_SEMI;
                  ",": kind = K_COMMA;
                  "(": kind = K_LPAREN;
                  ")": kind = K_RPAREN;
                  "{": kind = K_LBRACE;
                  "}": kind = K_RBRACE;
                  "[": kind = K_LBRACKET;
                  "]": kind = K_RBRACKET;
                  ":": kind = K_COLON;
                  default: kind = K_UNKNOWN;
               endcase
               if (kind != K_END) begin
                  r[n[1:0]] = mk(ITEM_TOKEN, kind, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
                  n = n + 3'd1;
               end
            end
         end

         // advance the position on every consumed byte
         if (c == 8'h0A) begin
            if (cur_line_in != 16'hFFFF) cur_line_in = cur_line_in + 16'd1;
            cur_col_in = 16'd1;
         end else if (cur_col_in != 16'hFFFF) begin
            cur_col_in = cur_col_in + 16'd1;
         end
      end

      if (item.end_of_source) begin
         kind = K_END;
         case (mode_in)
            M_SLASH: kind = K_SLASH;
            M_MINUS: kind = K_MINUS;
            M_OP1:   kind = single_op(held_in);
            M_INT: begin
               low = neg_in ? 32'd0 - mant_in[31:0] : mant_in[31:0];
               r[n[1:0]] = mk(ITEM_TOKEN, K_INT, 8'd0, start_line_in, start_col_in,
                              {{32{low[31]}}, low}, 5'd0);
               n = n + 3'd1;
            end
            M_FRAC: begin
               r[n[1:0]] = mk(ITEM_TOKEN, K_DEC, 8'd0, start_line_in, start_col_in,
                              neg_in ? 64'd0 - mant_in : mant_in, frac_in);
               n = n + 3'd1;
            end
            M_ESCAPE: begin
               r[n[1:0]] = mk(ITEM_TEXT, K_STR, "\\", start_line_in, start_col_in, 64'd0, 5'd0);
               n = n + 3'd1;
               kind = K_STR;
            end
            M_STRING: kind = K_STR;
            M_IDENT: begin
               kind = K_IDENT;
               for (int k = 0; k < 12; k++)
                  if (kw_in[k] && tlen_in == 9'(kw_len(k))) kind = K_KW0 + 6'(k);
            end
            default: kind = K_END;
         endcase
         if (kind != K_END) begin
            r[n[1:0]] = mk(ITEM_TOKEN, kind, 8'd0, start_line_in, start_col_in, 64'd0, 5'd0);
            n = n + 3'd1;
         end
         r[n[1:0]] = mk(ITEM_TOKEN, K_END, 8'd0, cur_line_in, cur_col_in, 64'd0, 5'd0);
         n = n + 3'd1;
         // drop back to the reset state
         mode_in = M_IDLE; held_in = 8'd0;
         cur_line_in = 16'd1; cur_col_in = 16'd1;
         start_line_in = 16'd1; start_col_in = 16'd1;
         mant_in = 64'd0; frac_in = 5'd0; neg_in = 1'b0;
         tlen_in = 9'd0; kw_in = 12'hFFF;
      end

      if (n != 3'd0) r[2'(n - 3'd1)].last_of_run = 1'b1;
      results = r;
      result_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; held_ff <= 8'd0;
         cur_line_ff <= 16'd1; cur_col_ff <= 16'd1;
         start_line_ff <= 16'd1; start_col_ff <= 16'd1;
         mant_ff <= 64'd0; frac_ff <= 5'd0; neg_ff <= 1'b0;
         tlen_ff <= 9'd0; kw_ff <= 12'hFFF;
      end else if (step_go) begin
         mode_ff <= mode_in; held_ff <= held_in;
         cur_line_ff <= cur_line_in; cur_col_ff <= cur_col_in;
         start_line_ff <= start_line_in; start_col_ff <= start_col_in;
         mant_ff <= mant_in; frac_ff <= frac_in; neg_ff <= neg_in;
         tlen_ff <= tlen_in; kw_ff <= kw_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sct_result_queue.sv =====
// Result queue: takes up to four results a cycle, hands out one while rsp_stall is low.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_result_queue
   import sct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_go,
   input  wire rsp_type push_data [MAX_RESULTS],
   input  wire logic [2:0] push_count,
   output logic         room_ok,
   output logic [3:0]   level,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   rsp_type    slot_ff [QUEUE_DEPTH];
   logic [2:0] wr_ff, rd_ff;
   logic [3:0] count_ff;
   logic       pop;
   logic [2:0] n;

   assign n         = push_go ? push_count : 3'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = count_ff != 4'd0;
   assign rsp_data  = slot_ff[rd_ff];
   assign room_ok   = count_ff <= 4'(QUEUE_DEPTH - MAX_RESULTS);
   assign level     = count_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (3'(k) < n) slot_ff[wr_ff + 3'(k)] <= push_data[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 3'd0; rd_ff <= 3'd0; count_ff <= 4'd0;
      end else begin
         wr_ff    <= wr_ff + n;
         rd_ff    <= rd_ff + 3'(pop);
         count_ff <= count_ff + 4'(n) - 4'(pop);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/source_code_tokenizer.sv =====
// Top level of the source code tokenizer: input register, lexer, result queue.
// Depends on sct_pkg, sct_lexer and sct_result_queue.
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer: feed one source byte per req transaction and collect
// tokens and echoed text characters on the rsp channel. A byte is taken into
// an input register, lexed by the scanner, and its zero to four results land
// in an eight-entry result queue. The block takes one byte per cycle as long
// as the queue has room for four more results; when a run of bytes yields
// more than one result each, or the consumer stalls, req_stall rises until
// the queue drains to four entries. A byte is registered in the input
// register, its results are registered in the result queue, and rsp shows
// the queue head. An item with end_of_source set flushes the pending token,
// emits the end token and resets the position.
module source_code_tokenizer
   import sct_pkg::*;
#(
   parameter int STRING_LIMIT = 256,
   parameter int NAME_LIMIT   = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // input register
   logic    in_valid_ff;
   req_type in_data_ff;

   rsp_type    results [MAX_RESULTS];
   logic [2:0] result_count;
   logic       room_ok;
   logic [3:0] level;
   logic       step_go;

   // lex the held transaction once the queue can take its worst case
   assign step_go   = in_valid_ff && room_ok;
   assign req_stall = in_valid_ff && !room_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload: advance whenever the register is free
   always_ff @(posedge clock) begin
      if (!req_stall) in_data_ff <= req_data;
   end

   sct_lexer #(
      .STRING_LIMIT (STRING_LIMIT),
      .NAME_LIMIT   (NAME_LIMIT)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step_go      (step_go),
      .item         (in_data_ff),
      .results      (results),
      .result_count (result_count)
   );

   sct_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_go    (step_go),
      .push_data  (results),
      .push_count (result_count),
      .room_ok    (room_ok),
      .level      (level),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      step_go |-> result_count <= 3'(MAX_RESULTS))
      else $error("lexer produced more results than allowed");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      level <= 4'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (step_go && result_count != 3'd0) |=> rsp_valid)
      else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_source_code_tokenizer.sv =====
// Testbench of the source code tokenizer: directed byte table, long runs, then random source text.
// Every transaction is checked against an in-bench lexer model; depends on sct_pkg and the RTL.
`timescale 1ns / 1ps

module tb_source_code_tokenizer;
   import sct_pkg::*;

   localparam int STR_LIM  = 256;
   localparam int NAME_LIM = 64;
   localparam logic [63:0] MANT_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      SC_IDLE, SC_SLASH, SC_COMMENT, SC_MINUS, SC_OP1, SC_INT, SC_FRAC,
      SC_STRING, SC_ESCAPE, SC_IDENT
   } scan_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   source_code_tokenizer #(.STRING_LIMIT(STR_LIM), .NAME_LIMIT(NAME_LIM)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lexer model state
   scan_type    lx_mode;
   logic [7:0]  lx_held;
   logic [15:0] lx_line, lx_col, lx_sline, lx_scol;
   logic [63:0] lx_mant;
   logic [4:0]  lx_frac;
   logic        lx_neg;
   logic [8:0]  lx_tlen;
   logic [11:0] lx_kwm;

   rsp_type token_queue[$];   // tokens and text characters still to arrive
   rsp_type step_out[$];      // results of the item being lexed
   int      fail_count;

   // Directed rows: byte, has_byte, end, and an optional typed-in expectation
   typedef struct {
      logic [7:0] b;
      logic       hb;
      logic       eos;
      logic       typed;
      rsp_type    want;
   } row_type;
   row_type dir_rows[$];

   function automatic string kw_name(int k);
      case (k)
         0: return "fn";    1: return "rn";    2: return "if";       3: return "for";
         4: return "while"; 5: return "in";    6: return "out";      7: return "time";
         8: return "break"; 9: return "continue"; 10: return "array"; default: return "http";
      endcase
   endfunction

   function automatic void push(logic ik, logic [5:0] kind, logic [7:0] ch,
                                logic [15:0] ln, logic [15:0] col,
                                logic [63:0] val, logic [4:0] fr);
      rsp_type r;
      r = '0;
      r.item_kind = ik; r.token_kind = kind; r.text_char = ch;
      r.line = ln; r.column = col; r.number_value = val; r.fraction_digits = fr;
      if (step_out.size() < MAX_RESULTS) step_out.push_back(r);
   endfunction

   function automatic void put_tok(logic [5:0] kind);
      push(ITEM_TOKEN, kind, 8'd0, lx_sline, lx_scol, 64'd0, 5'd0);
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void add_digit(logic [7:0] c);
      logic [63:0] d;
      d = c - "0";
      if (lx_mant > (MANT_TOP - d) / 10) lx_mant = MANT_TOP;
      else lx_mant = lx_mant * 10 + d;
   endfunction

   function automatic void put_int();
      logic [31:0] lo;
      lo = lx_mant[31:0];
      if (lx_neg) lo = -lo;
      push(ITEM_TOKEN, K_INT, 8'd0, lx_sline, lx_scol, {{32{lo[31]}}, lo}, 5'd0);
   endfunction

   function automatic void put_dec();
      push(ITEM_TOKEN, K_DEC, 8'd0, lx_sline, lx_scol, lx_neg ? -lx_mant : lx_mant, lx_frac);
   endfunction

   function automatic void put_ident();
      logic [5:0] kind;
      string      s;
      kind = K_IDENT;
      for (int k = 0; k < 12; k++) begin
         s = kw_name(k);
         if (lx_kwm[k] && lx_tlen == s.len()) kind = K_KW0 + 6'(k);
      end
      put_tok(kind);
   endfunction

   function automatic void ident_char(logic [7:0] c);
      string s;
      for (int k = 0; k < 12; k++) begin
         s = kw_name(k);
         if (lx_tlen >= s.len() || s[lx_tlen] != c) lx_kwm[k] = 1'b0;
      end
      if (lx_tlen < NAME_LIM - 1) push(ITEM_TEXT, K_IDENT, c, lx_sline, lx_scol, 64'd0, 5'd0);
      if (lx_tlen < 511) lx_tlen++;
   endfunction

   function automatic logic [5:0] single_op(logic [7:0] c);
      case (c)
         "+": return K_PLUS;
         "=": return K_ASSIGN;
         "!": return K_NOT;
         "<": return K_LT;
         ">": return K_GT;
         default: return K_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] pair_op(logic [7:0] a, logic [7:0] c);
      if (a == "+" && c == "+") return K_PLUSPLUS;
      if (a == "=" && c == "=") return K_EQ;
      if (a == "!" && c == "=") return K_NEQ;
      if (a == "<" && c == "=") return K_LTE;
      if (a == ">" && c == "=") return K_GTE;
      if (a == "&" && c == "&") return K_AND;
      if (a == "|" && c == "|") return K_OR;
      return K_END;
   endfunction

   function automatic void lex_reset();
      lx_mode = SC_IDLE; lx_held = '0;
      lx_line = 1; lx_col = 1; lx_sline = 1; lx_scol = 1;
      lx_mant = '0; lx_frac = '0; lx_neg = 1'b0; lx_tlen = '0; lx_kwm = '1;
   endfunction

   // Start a new token (or skip) at the current position
   function automatic void lex_idle(logic [7:0] c);
      lx_sline = lx_line;
      lx_scol  = lx_col;
      lx_mode  = SC_IDLE;
      if (c == " " || (c >= 9 && c <= 13)) return;
      if (digit(c)) begin
         lx_mode = SC_INT; lx_mant = c - "0"; lx_neg = 1'b0; lx_frac = '0;
         return;
      end
      if (alpha(c) || c == "_" || c == "$") begin
         lx_mode = SC_IDENT; lx_tlen = '0; lx_kwm = '1;
         ident_char(c);
         return;
      end
      case (c)
         "/": lx_mode = SC_SLASH;
         "-": lx_mode = SC_MINUS;
         "\"": begin lx_mode = SC_STRING; lx_tlen = '0; end
         "+", "=", "!", "<", ">", "&", "|": begin lx_mode = SC_OP1; lx_held = c; end
         "*": put_tok(K_STAR);
         "%": put_tok(K_PERCENT);
         ";": put_tok(K_SEMI);
         ",": put_tok(K_COMMA);
         "(": put_tok(K_LPAREN);
         ")": put_tok(K_RPAREN);
         "{": put_tok(K_LBRACE);
         "}": put_tok(K_RBRACE);
         "[": put_tok(K_LBRACKET);
         "]": put_tok(K_RBRACKET);
         ":": put_tok(K_COLON);
         default: put_tok(K_UNKNOWN);
      endcase
   endfunction

   // Returns 1 when the byte also starts a new token from idle
   function automatic bit lex_byte(logic [7:0] c);
      logic [5:0] k;
      case (lx_mode)
         SC_SLASH: begin
            if (c == "/") begin lx_mode = SC_COMMENT; return 0; end
            put_tok(K_SLASH);
         end
         SC_COMMENT: begin
            if (c == 8'd10) lx_mode = SC_IDLE;
            return 0;
         end
         SC_MINUS: begin
            if (c == "-") begin put_tok(K_MINUSMINUS); lx_mode = SC_IDLE; return 0; end
            if (digit(c)) begin
               lx_mode = SC_INT; lx_mant = c - "0"; lx_neg = 1'b1; lx_frac = '0;
               return 0;
            end
            put_tok(K_MINUS);
         end
         SC_OP1: begin
            k = pair_op(lx_held, c);
            if (k != K_END) begin put_tok(k); lx_mode = SC_IDLE; return 0; end
            put_tok(single_op(lx_held));
         end
         SC_INT: begin
            if (digit(c)) begin add_digit(c); return 0; end
            if (c == ".") begin lx_mode = SC_FRAC; lx_frac = '0; return 0; end
            put_int();
         end
         SC_FRAC: begin
            if (digit(c)) begin
               if (lx_frac < 18) begin add_digit(c); lx_frac++; end
               return 0;
            end
            put_dec();
         end
         SC_STRING: begin
            if (lx_tlen >= STR_LIM - 1) begin
               put_tok(K_STR);
               if (c == "\"") begin lx_mode = SC_IDLE; return 0; end
            end else begin
               if (c == "\"") begin put_tok(K_STR); lx_mode = SC_IDLE; return 0; end
               if (c == "\\") begin lx_mode = SC_ESCAPE; return 0; end
               push(ITEM_TEXT, K_STR, c, lx_sline, lx_scol, 64'd0, 5'd0);
               lx_tlen++;
               return 0;
            end
         end
         SC_ESCAPE: begin
            k = '0;
            push(ITEM_TEXT, K_STR, (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : c,
                 lx_sline, lx_scol, 64'd0, 5'd0);
            lx_tlen++;
            lx_mode = SC_STRING;
            return 0;
         end
         SC_IDENT: begin
            if (alpha(c) || digit(c) || c == "_") begin ident_char(c); return 0; end
            put_ident();
         end
         default: ;
      endcase
      return 1;
   endfunction

   // Predict the results of one accepted transaction and queue them
   function automatic void predict_tokens(req_type rq);
      step_out.delete();
      if (rq.has_byte) begin
         if (lex_byte(rq.source_byte)) lex_idle(rq.source_byte);
         if (rq.source_byte == 8'd10) begin
            if (lx_line != 16'hFFFF) lx_line++;
            lx_col = 1;
         end else if (lx_col != 16'hFFFF) lx_col++;
      end
      if (rq.end_of_source) begin
         case (lx_mode)
            SC_SLASH:  put_tok(K_SLASH);
            SC_MINUS:  put_tok(K_MINUS);
            SC_OP1:    put_tok(single_op(lx_held));
            SC_INT:    put_int();
            SC_FRAC:   put_dec();
            SC_ESCAPE: begin
               push(ITEM_TEXT, K_STR, "\\", lx_sline, lx_scol, 64'd0, 5'd0);
               put_tok(K_STR);
            end
            SC_STRING: put_tok(K_STR);
            SC_IDENT:  put_ident();
            default: ;
         endcase
         push(ITEM_TOKEN, K_END, 8'd0, lx_line, lx_col, 64'd0, 5'd0);
         lex_reset();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
      foreach (step_out[i]) token_queue.push_back(step_out[i]);
   endfunction

   function automatic void add_row(logic [7:0] b, logic hb, logic eos);
      row_type r;
      r.b = b; r.hb = hb; r.eos = eos; r.typed = 1'b0; r.want = '0;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b1, 1'b0);
   endfunction

   // Add a row whose single result is typed in by hand
   function automatic void add_typed(logic [7:0] b, logic eos, logic [5:0] kind,
                                     logic [15:0] ln, logic [15:0] col);
      row_type r;
      r.b = b; r.hb = 1'b1; r.eos = eos; r.typed = 1'b1;
      r.want = '0;
      r.want.token_kind = kind; r.want.line = ln; r.want.column = col;
      r.want.last_of_run = 1'b1;
      dir_rows.push_back(r);
   endfunction

   // Sender side
   req_type stim_q[$];
   logic    hold_sender;
   int      quiet_from, quiet_to, req_count, rsp_count;

   task automatic drive_all();
      int      idx;
      rsp_type got;
      idx = 0;
      while (idx < stim_q.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            predict_tokens(req_data);
            // typed rows: the single predicted result must match the table
            if (idx < dir_rows.size() && dir_rows[idx].typed) begin
               got = '0;
               if (step_out.size() != 0) got = step_out[0];
               if (step_out.size() != 1 || got !== dir_rows[idx].want) begin
                  $display("%0t: mismatch expected %p actual %p", $time,
                           dir_rows[idx].want, got);
                  fail_count++;
               end
            end
            idx++;
            req_count++;
         end
         if (idx < stim_q.size() && !hold_sender &&
             (req_count inside {[quiet_from:quiet_to]} || $urandom_range(99) >= 21)) begin
            req_valid <= 1'b1;
            req_data  <= stim_q[idx];
         end else if (!(req_valid && req_stall)) begin
            req_valid <= 1'b0;
         end
      end
   endtask

   // Receiver side: stall at random, compare every accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (token_queue.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count++;
            end else if (token_queue[0] !== rsp_data) begin
               $display("%0t: mismatch expected %p actual %p", $time, token_queue[0], rsp_data);
               fail_count++;
               void'(token_queue.pop_front());
            end else begin
               void'(token_queue.pop_front());
            end
         end
         rsp_stall <= !(rsp_count inside {[quiet_from:quiet_to]}) && ($urandom_range(99) < 21);
      end
   end

   function automatic logic [7:0] rand_byte_of(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   // Append a random well-formed fragment, or noise now and then
   function automatic void add_fragment();
      string kws;
      int    n;
      n = 0;
      case ($urandom_range(9))
         0: begin
            if ($urandom_range(1)) stim_q.push_back({8'h2D, 1'b1, 1'b0});
            n = $urandom_range(1, 22);
            for (int i = 0; i < n; i++) stim_q.push_back({rand_byte_of("0123456789"), 2'b10});
            if ($urandom_range(1)) begin
               stim_q.push_back({8'h2E, 2'b10});
               n = $urandom_range(0, 21);
               for (int i = 0; i < n; i++) stim_q.push_back({rand_byte_of("0123456789"), 2'b10});
            end
         end
         1: begin
            kws = kw_name($urandom_range(11));
            for (int i = 0; i < kws.len(); i++) stim_q.push_back({kws[i], 2'b10});
         end
         2: begin
            stim_q.push_back({rand_byte_of("abzAZ_$"), 2'b10});
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) stim_q.push_back({rand_byte_of("aeinrtxZ09_$"), 2'b10});
         end
         3: begin
            stim_q.push_back({8'h22, 2'b10});
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) stim_q.push_back({8'($urandom_range(32, 126)), 2'b10});
            stim_q.push_back({8'h22, 2'b10});
         end
         4: begin
            stim_q.push_back({rand_byte_of("+=!<>&|-/"), 2'b10});
            stim_q.push_back({rand_byte_of("+=&|-/a1 "), 2'b10});
         end
         5: stim_q.push_back({rand_byte_of("*%;,(){}[]:"), 2'b10});
         6: stim_q.push_back({rand_byte_of(" \t\n\r"), 2'b10});
         7: begin
            stim_q.push_back({8'h2F, 2'b10});
            stim_q.push_back({8'h2F, 2'b10});
            stim_q.push_back({8'($urandom_range(255)), 2'b10});
            stim_q.push_back({8'h0A, 2'b10});
         end
         8: stim_q.push_back({8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0});
         default: stim_q.push_back({8'($urandom_range(255)), 1'($urandom_range(1)),
                                    1'($urandom_range(3) == 0)});
      endcase
   endfunction

   initial begin
      int rand_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      hold_sender = 1'b0;
      fail_count = 0;
      req_count = 0;
      rsp_count = 0;
      quiet_from = 200;
      quiet_to = 260;
      lex_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table: typed expectations where the answer is plain
      add_typed("*", 1'b0, K_STAR, 16'd1, 16'd1);          // first token after reset
      add_typed(8'hFF, 1'b0, K_UNKNOWN, 16'd1, 16'd2);     // high byte is unknown
      add_typed(8'h00, 1'b0, K_UNKNOWN, 16'd1, 16'd3);     // low byte is unknown
      add_text("&x|y ");                                   // lone and / or
      add_text("-7 -- 99999999999999999999 ");             // overflow saturates
      add_text("1.1234567890123456789012 -0.0 3. ");       // dropped digits, neg zero
      add_text("$a fn continue http time while array_ ");
      add_text("\"a\\n\\t\\q\"\n// note\n<= >= != == ++ && || ");
      add_text("\"\\");
      add_row(8'h00, 1'b0, 1'b1);                          // escape at end of source
      add_row(8'h00, 1'b0, 1'b0);                          // idle transaction
      add_row("/", 1'b1, 1'b1);                            // slash flushed at end
      add_row("-", 1'b1, 1'b1);
      foreach (dir_rows[i]) stim_q.push_back({dir_rows[i].b, dir_rows[i].hb, dir_rows[i].eos});

      // Long name, long string, and a deep column
      rand_start = stim_q.size();
      for (int i = 0; i < 70; i++) stim_q.push_back({8'h61, 2'b10});
      stim_q.push_back({8'h22, 2'b10});
      for (int i = 0; i < 256; i++) stim_q.push_back({8'($urandom_range(97, 122)), 2'b10});
      stim_q.push_back({8'h22, 2'b10});
      stim_q.push_back({8'h00, 2'b01});

      // Random source text
      while (stim_q.size() < rand_start + 330 + 60) add_fragment();
      stim_q.push_back({8'h00, 2'b01});

      fork
         drive_all();
         begin
            // Pause the sender until the block has drained
            while (req_count < rand_start + 100) @(posedge clock);
            hold_sender = 1'b1;
            while (token_queue.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
      join

      @(posedge clock);
      req_valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
